// File: rtl/rca_pkg.sv
// Package for the refcounted compacting allocator.
// Holds commands, status codes and the table entry type; no dependencies.
package rca_pkg;

  localparam int unsigned POOL_BYTES_DEF  = 65536;
  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned HANDLE_W        = 16;
  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned SIZE_W          = 17;
  localparam int unsigned REFS_W          = 16;
  localparam int unsigned STATUS_W        = 3;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_RETRIEVE = 2'd1,
    CMD_ADD_REF  = 2'd2,
    CMD_DROP_REF = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   start;
    logic [SIZE_W-1:0]   length;
    logic [REFS_W-1:0]   refs;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/refcounted_compacting_allocator.sv
// Top level of the refcounted compacting allocator: handle table over a byte pool.
// Uses rca_pkg and rca_table_ram.
//
// Input item (in_*): cmd, req_size, handle. One result item (out_*) per input:
// status, out_handle, start_addr, compacted.
// Items are processed one at a time. The entry table sits in a simple dual-port
// synchronous RAM (one read and one write a cycle, read data registered).
// Insert without compaction, bad size, full, null handle or empty table: answered
// straight from idle. Retrieve/add/drop read the slots in order until the handle
// matches; not found reads every live entry. A drop that removes its entry shifts
// the later entries down one slot each. Compaction walks the live entries, packing
// their start addresses from zero, before the append.
// Reset clears the live count, the free index and sets the next handle to one;
// the table contents need no clearing. The result is held in an output
// register; while the receiver stalls no new item is accepted.
module refcounted_compacting_allocator #(
  parameter int unsigned POOL_BYTES  = rca_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_ENTRIES = rca_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], req_size[18:2], handle[34:19], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[2:0], out_handle[18:3], start_addr[34:19],
                                  // compacted[35], zero pad
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = rca_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CMP_RD, S_CMP_WR, S_SRCH_RD, S_SRCH_CHK, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [CW-1:0] live_r;
  logic [SW:0] free_r;
  logic [rca_pkg::HANDLE_W-1:0] next_h_r;
  logic [1:0] cmd_r;
  logic [SW-1:0] size_r;
  logic [rca_pkg::HANDLE_W-1:0] h_r;
  logic [CW-1:0] idx_r;
  logic [SW:0] acc_r;
  logic [rca_pkg::STATUS_W-1:0] st_r;
  logic [rca_pkg::HANDLE_W-1:0] oh_r;
  logic [rca_pkg::ADDR_W-1:0] sa_r;
  logic comp_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  rca_pkg::entry_t wdata, rdata;
  logic [rca_pkg::ENTRY_W-1:0] rdata_raw;

  rca_table_ram #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = rca_pkg::entry_t'(rdata_raw);

  logic [1:0] in_cmd;
  logic [SW-1:0] in_size;
  logic [rca_pkg::HANDLE_W-1:0] in_h;
  assign in_cmd  = in_tdata[1:0];
  assign in_size = in_tdata[18:2];
  assign in_h    = in_tdata[34:19];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {4'd0, comp_r, sa_r, oh_r, st_r};

  logic [SW:0] sum_in, sum_r;
  assign sum_in = {1'b0, free_r[SW-1:0]} + {1'b0, in_size};
  assign sum_r  = {1'b0, free_r[SW-1:0]} + {1'b0, size_r};

  logic [rca_pkg::HANDLE_W-1:0] next_h_inc;
  assign next_h_inc = (next_h_r == '1) ? rca_pkg::HANDLE_W'(1) : next_h_r + 1'b1;

  logic [CW-1:0] idx_inc;
  assign idx_inc = idx_r + 1'b1;

  // append entry at live_r using free_r (comb helper, drives RAM write)
  logic do_append;
  logic [rca_pkg::REFS_W-1:0] refs_dec;
  assign refs_dec = rdata.refs - 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    raddr = idx_r[AW-1:0];
    do_append = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        raddr = '0;
        if (in_tvalid && rca_pkg::cmd_t'(in_cmd) == rca_pkg::CMD_INSERT && in_size != '0
            && live_r < CW'(MAX_ENTRIES) && sum_in <= (SW+1)'(POOL_BYTES)) begin
          do_append = 1'b1;
        end
      end
      S_CMP_WR: begin
        we = 1'b1;
        wdata.start = acc_r[rca_pkg::ADDR_W-1:0];
      end
      S_SRCH_CHK: begin
        if (rdata.handle == h_r) begin
          if (rca_pkg::cmd_t'(cmd_r) == rca_pkg::CMD_ADD_REF && rdata.refs != '1) begin
            we = 1'b1;
            wdata.refs = rdata.refs + 1'b1;
          end else if (rca_pkg::cmd_t'(cmd_r) == rca_pkg::CMD_DROP_REF && refs_dec != '0) begin
            we = 1'b1;
            wdata.refs = refs_dec;
          end
        end
      end
      S_SHIFT_RD: raddr = idx_inc[AW-1:0];
      S_SHIFT_WR: we = 1'b1;
      default: ;
    endcase
    if (do_append || (state_r == S_CMP_RD && idx_r == live_r && sum_r <= (SW+1)'(POOL_BYTES))) begin
      we    = 1'b1;
      waddr = live_r[AW-1:0];
      wdata.handle = next_h_r;
      wdata.start  = free_r[rca_pkg::ADDR_W-1:0];
      wdata.length = (state_r == S_IDLE) ? in_size : size_r;
      wdata.refs   = rca_pkg::REFS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      live_r   <= '0;
      free_r   <= '0;
      next_h_r <= rca_pkg::HANDLE_W'(1);
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r  <= in_cmd;
          size_r <= in_size;
          h_r    <= in_h;
          idx_r  <= '0;
          acc_r  <= '0;
          st_r   <= rca_pkg::ST_OK;
          oh_r   <= '0;
          sa_r   <= '0;
          comp_r <= 1'b0;
          if (rca_pkg::cmd_t'(in_cmd) == rca_pkg::CMD_INSERT) begin
            if (in_size == '0) begin
              st_r <= rca_pkg::ST_BAD_SIZE;
              state_r <= S_DONE;
            end else if (live_r >= CW'(MAX_ENTRIES)) begin
              st_r <= rca_pkg::ST_FULL;
              state_r <= S_DONE;
            end else if (do_append) begin
              live_r   <= live_r + 1'b1;
              oh_r     <= next_h_r;
              sa_r     <= free_r[rca_pkg::ADDR_W-1:0];
              free_r   <= sum_in;
              next_h_r <= next_h_inc;
              state_r  <= S_DONE;
            end else begin
              // packed total starts at zero; set again after the last live entry
              free_r  <= '0;
              comp_r  <= 1'b1;
              state_r <= S_CMP_RD;
            end
          end else if (in_h == '0 || live_r == '0) begin
            st_r <= rca_pkg::ST_NOT_FOUND;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SRCH_CHK;
          end
        end
        S_CMP_RD: begin
          if (idx_r == live_r) begin
            if (sum_r <= (SW+1)'(POOL_BYTES)) begin
              live_r   <= live_r + 1'b1;
              oh_r     <= next_h_r;
              sa_r     <= free_r[rca_pkg::ADDR_W-1:0];
              free_r   <= sum_r;
              next_h_r <= next_h_inc;
            end else begin
              st_r <= rca_pkg::ST_NO_SPACE;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          acc_r <= acc_r + {1'b0, rdata.length};
          idx_r <= idx_inc;
          if (idx_inc == live_r) begin
            free_r <= acc_r + {1'b0, rdata.length};
          end
          state_r <= S_CMP_RD;
        end
        S_SRCH_RD: state_r <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (rdata.handle == h_r) begin
            oh_r <= h_r;
            sa_r <= rdata.start;
            if (rca_pkg::cmd_t'(cmd_r) == rca_pkg::CMD_DROP_REF && refs_dec == '0) begin
              if (idx_inc == live_r) begin
                live_r  <= live_r - 1'b1;
                state_r <= S_DONE;
              end else begin
                state_r <= S_SHIFT_RD;
              end
            end else begin
              state_r <= S_DONE;
            end
          end else if (idx_inc == live_r) begin
            st_r <= rca_pkg::ST_NOT_FOUND;
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_inc;
            state_r <= S_SRCH_RD;
          end
        end
        S_SHIFT_RD: state_r <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx_r <= idx_inc;
          if (idx_inc + 1'b1 == live_r) begin
            live_r  <= live_r - 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SHIFT_RD;
          end
        end
        S_DONE: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rca_table_ram.sv
// Entry table memory for the refcounted compacting allocator.
// One write port, one registered read port; uses rca_pkg.
module rca_table_ram #(
  parameter int unsigned DEPTH = rca_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [rca_pkg::ENTRY_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [rca_pkg::ENTRY_W-1:0]   rdata
);

  logic [rca_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/refcounted_compacting_allocator_tb.sv
// Testbench for refcounted_compacting_allocator: drives command items, predicts each
// result with an in-bench handle table model and checks results in order.
// Depends on rca_pkg and the allocator RTL.
module refcounted_compacting_allocator_tb;

  localparam int unsigned POOL = 65536;
  localparam int unsigned NENT = 32;
  localparam longint LIMIT = 3000000;

  typedef struct packed {
    logic [15:0]   handle;
    logic [16:0]   req_size;
    rca_pkg::cmd_t cmd;
  } cmd_item_t;

  typedef struct packed {
    logic             compacted;
    logic [15:0]      start_addr;
    logic [15:0]      out_handle;
    rca_pkg::status_t status;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;

  refcounted_compacting_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow table
  logic [15:0] tbl_handle [NENT];
  logic [15:0] tbl_start  [NENT];
  logic [16:0] tbl_len    [NENT];
  logic [15:0] tbl_refs   [NENT];
  int unsigned n_live = 0;
  logic [16:0] free_idx = '0;
  logic [15:0] next_h = 16'd1;

  cmd_item_t  pending_cmds[$];
  rsp_item_t  expected_rsps[$];
  logic [15:0] issued[$];
  int  errors = 0;
  bit  stim_done = 0;
  bit  hold_off_req = 0;
  bit  drain_req = 0;
  longint cycles = 0;

  function automatic rsp_item_t alloc_step(cmd_item_t c);
    rsp_item_t r;
    int slot;
    int unsigned addr;
    r = '{compacted: 1'b0, start_addr: '0, out_handle: '0, status: rca_pkg::ST_OK};
    if (c.cmd == rca_pkg::CMD_INSERT) begin
      if (c.req_size == 0) r.status = rca_pkg::ST_BAD_SIZE;
      else if (n_live >= NENT) r.status = rca_pkg::ST_FULL;
      else begin
        if (int'(free_idx) + int'(c.req_size) > POOL) begin
          addr = 0;
          for (int k = 0; k < n_live; k++) begin
            tbl_start[k] = addr[15:0];
            addr += tbl_len[k];
          end
          free_idx = addr[16:0];
          r.compacted = 1'b1;
        end
        if (int'(free_idx) + int'(c.req_size) > POOL) r.status = rca_pkg::ST_NO_SPACE;
        else begin
          tbl_handle[n_live] = next_h;
          tbl_start[n_live] = free_idx[15:0];
          tbl_len[n_live] = c.req_size;
          tbl_refs[n_live] = 16'd1;
          n_live++;
          r.out_handle = next_h;
          r.start_addr = free_idx[15:0];
          free_idx = free_idx + c.req_size;
          next_h = (next_h == 16'hFFFF) ? 16'd1 : next_h + 16'd1;
        end
      end
    end else begin
      slot = -1;
      if (c.handle != 0)
        for (int k = n_live - 1; k >= 0; k--)
          if (tbl_handle[k] == c.handle) slot = k;
      if (slot < 0) r.status = rca_pkg::ST_NOT_FOUND;
      else begin
        r.out_handle = c.handle;
        r.start_addr = tbl_start[slot];
        if (c.cmd == rca_pkg::CMD_ADD_REF) begin
          if (tbl_refs[slot] != 16'hFFFF) tbl_refs[slot]++;
        end else if (c.cmd == rca_pkg::CMD_DROP_REF) begin
          tbl_refs[slot]--;
          if (tbl_refs[slot] == 0) begin
            for (int k = slot; k + 1 < n_live; k++) begin
              tbl_handle[k] = tbl_handle[k + 1];
              tbl_start[k] = tbl_start[k + 1];
              tbl_len[k] = tbl_len[k + 1];
              tbl_refs[k] = tbl_refs[k + 1];
            end
            n_live--;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && issued.size() > 0) return issued[$urandom_range(0, issued.size() - 1)];
    if (r < 85) return 16'd0;
    if (r < 90) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 17'($urandom_range(1, 4096));
    if (r < 80) return 17'($urandom_range(4096, 20000));
    if (r < 88) return 17'($urandom_range(20000, 65536));
    if (r < 93) return 17'd0;
    if (r < 97) return 17'd65536;
    return 17'($urandom);
  endfunction

  task automatic push_cmd(rca_pkg::cmd_t c, logic [16:0] sz, logic [15:0] h);
    pending_cmds.push_back('{handle: h, req_size: sz, cmd: c});
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed
    push_cmd(rca_pkg::CMD_INSERT, 17'd0, 16'd0);
    push_cmd(rca_pkg::CMD_RETRIEVE, 17'd0, 16'd0);
    push_cmd(rca_pkg::CMD_INSERT, 17'h1FFFF, 16'hFFFF);
    push_cmd(rca_pkg::CMD_INSERT, 17'd65536, 16'd0);
    push_cmd(rca_pkg::CMD_INSERT, 17'd1, 16'd0);
    push_cmd(rca_pkg::CMD_RETRIEVE, 17'd0, 16'd1);
    push_cmd(rca_pkg::CMD_DROP_REF, 17'd0, 16'd1);
    push_cmd(rca_pkg::CMD_INSERT, 17'd100, 16'd0);
    push_cmd(rca_pkg::CMD_INSERT, 17'd65500, 16'd0);
    push_cmd(rca_pkg::CMD_ADD_REF, 17'h1FFFF, 16'd3);
    push_cmd(rca_pkg::CMD_DROP_REF, 17'd0, 16'd3);
    push_cmd(rca_pkg::CMD_DROP_REF, 17'd0, 16'd3);
    push_cmd(rca_pkg::CMD_DROP_REF, 17'd0, 16'd12345);
    push_cmd(rca_pkg::CMD_ADD_REF, 17'd0, 16'd0);
    for (int k = 0; k < 33; k++) push_cmd(rca_pkg::CMD_INSERT, 17'd10, 16'd0);
    for (int h = 4; h < 40; h++) push_cmd(rca_pkg::CMD_DROP_REF, 17'd0, 16'(h));
    // random phases plus pressure checks: an output hold-off and a drain
    for (int i = 0; i < 1000; i++) begin
      int r;
      if (i == 300) begin
        wait (pending_cmds.size() == 0);
        hold_off_req = 1;
        for (int k = 0; k < 20; k++) push_cmd(rca_pkg::CMD_INSERT, pick_size(), 16'd0);
        wait (pending_cmds.size() == 0 && !hold_off_req);
      end
      if (i == 600) begin
        wait (pending_cmds.size() == 0);
        drain_req = 1;
        wait (!drain_req);
      end
      r = $urandom_range(0, 99);
      if (r < 40) push_cmd(rca_pkg::CMD_INSERT, pick_size(), 16'($urandom));
      else if (r < 55) push_cmd(rca_pkg::CMD_RETRIEVE, 17'($urandom), pick_handle());
      else if (r < 70) push_cmd(rca_pkg::CMD_ADD_REF, 17'($urandom), pick_handle());
      else push_cmd(rca_pkg::CMD_DROP_REF, 17'($urandom), pick_handle());
      if (pending_cmds.size() > 8) wait (pending_cmds.size() < 4);
    end
    wait (pending_cmds.size() == 0);
    stim_done = 1;
  end

  // driver
  int burst_left = 0;
  int gap_left = 0;
  bit in_acc;
  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      rsp_item_t e;
      e = alloc_step(cmd_item_t'(in_tdata[34:0]));
      expected_rsps.push_back(e);
      if (in_tdata[1:0] == rca_pkg::CMD_INSERT && e.status == rca_pkg::ST_OK)
        issued.push_back(e.out_handle);
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) void'(pending_cmds.pop_front());
      if (!in_tvalid || in_acc) begin
        if (drain_req && !in_acc) begin
          if (expected_rsps.size() == 0) drain_req <= 0;
          in_tvalid <= 1'b0;
        end else if (gap_left > 0 || drain_req) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_item_t c;
          c = pending_cmds[0];
          in_tdata <= {5'd0, c};
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else burst_left <= burst_left - 1;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  int stall_cnt = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_off_req) begin
      out_tready <= 1'b0;
      if (hold_cnt >= 2000) begin
        hold_off_req <= 0;
        hold_cnt <= 0;
      end else hold_cnt <= hold_cnt + 1;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if ((stall_cnt / 200) % 2 == 0) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rsp_item_t got, want;
      got = rsp_item_t'(out_tdata[35:0]);
      if (expected_rsps.size() == 0) begin
        $error("unexpected result item %h", out_tdata);
        errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.out_handle !== want.out_handle) begin
          $error("out_handle exp %0d got %0d", want.out_handle, got.out_handle); errors++;
        end
        if (got.start_addr !== want.start_addr) begin
          $error("start_addr exp %0d got %0d", want.start_addr, got.start_addr); errors++;
        end
        if (got.compacted !== want.compacted) begin
          $error("compacted exp %0d got %0d", want.compacted, got.compacted); errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_rsps.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) $display("refcounted_compacting_allocator test passed");
    else $display("refcounted_compacting_allocator test failed");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("refcounted_compacting_allocator test failed");
      $finish;
    end
  end
endmodule
